### design/nsc_pkg.sv
// nsc_pkg: shared types, constants and helper functions of the nmea sentence checker
// used by nsc_sentence_core and nmea_sentence_checker_unit; no dependencies
package nsc_pkg;

    localparam int DEFAULT_FIELD_LIMIT = 32;

    localparam int BYTE_W   = 8;
    localparam int TYPE_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int ADDR_LEN = 5;
    localparam int ADDR_W   = ADDR_LEN * BYTE_W;
    localparam int POS_W    = 3;
    localparam int NUM_TYPES = 8;

    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;

    typedef enum logic [1:0] {
        CK_OK       = 2'd0,
        CK_MISMATCH = 2'd1,
        CK_NO_STAR  = 2'd2
    } ck_status_t;

    typedef enum logic [TYPE_W-1:0] {
        TYPE_UNKNOWN = 4'd0,
        TYPE_GLGSV   = 4'd1,
        TYPE_GPGSV   = 4'd2,
        TYPE_GNGLL   = 4'd3,
        TYPE_GNRMC   = 4'd4,
        TYPE_GNVTG   = 4'd5,
        TYPE_GNGGA   = 4'd6,
        TYPE_GNGSA   = 4'd7,
        TYPE_GNTXT   = 4'd8
    } sentence_type_t;

    // packed so that sentence_type sits in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] comma_count;
        ck_status_t         checksum_status;
        logic               type_enabled;
        sentence_type_t     sentence_type;
    } nsc_result_t;

    localparam int RESULT_W = $bits(nsc_result_t);
    localparam int RESULT_BYTES_W = ((RESULT_W + 7) / 8) * 8;

    function automatic sentence_type_t type_of(input logic [ADDR_W-1:0] addr);
        sentence_type_t t;
        t = TYPE_UNKNOWN;
        case (addr)
            {8'h47, 8'h4C, 8'h47, 8'h53, 8'h56}: t = TYPE_GLGSV;
            {8'h47, 8'h50, 8'h47, 8'h53, 8'h56}: t = TYPE_GPGSV;
            {8'h47, 8'h4E, 8'h47, 8'h4C, 8'h4C}: t = TYPE_GNGLL;
            {8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43}: t = TYPE_GNRMC;
            {8'h47, 8'h4E, 8'h56, 8'h54, 8'h47}: t = TYPE_GNVTG;
            {8'h47, 8'h4E, 8'h47, 8'h47, 8'h41}: t = TYPE_GNGGA;
            {8'h47, 8'h4E, 8'h47, 8'h53, 8'h41}: t = TYPE_GNGSA;
            {8'h47, 8'h4E, 8'h54, 8'h58, 8'h54}: t = TYPE_GNTXT;
            default: t = TYPE_UNKNOWN;
        endcase
        return t;
    endfunction

    // bit 4 set when the byte is no hex digit
    function automatic logic [4:0] nibble_of(input logic [BYTE_W-1:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b0, 4'(b - 8'h30)};
        end else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b0, 4'(b - 8'h37)};
        end else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b0, 4'(b - 8'h57)};
        end
        return r;
    endfunction

endpackage

### design/nmea_sentence_checker_unit.sv
// Streaming NMEA 0183 sentence checker. Accepts one received character per input
// transfer, one transfer per clock cycle sustained unless the result stalls; a
// sentence closed by CR or LF yields one result transfer through the input
// register and the result register around the per-byte update. Bytes outside a
// sentence and every other character give no result. The user must write
// filter_mask over the cfg channel while no sentence result is pending; unchecked.
// nmea_sentence_checker_unit: top level with input and result registers
// depends on nsc_pkg and nsc_sentence_core
module nmea_sentence_checker_unit import nsc_pkg::*; #(
    parameter int FIELD_LIMIT = DEFAULT_FIELD_LIMIT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [BYTE_W-1:0]         s_tdata,  // rx_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // sentence_type[3:0], type_enabled[4], checksum_status[6:5], comma_count[11:7]
    output logic [RESULT_BYTES_W-1:0] m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [7:0]                cfg_data  // filter_mask
);

    logic              in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_vld_reg, out_vld_next;
    nsc_result_t       out_res_reg;
    logic [7:0]        mask_reg;
    logic              advance;
    logic              res_hit;
    nsc_result_t       res;

    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {{(RESULT_BYTES_W - RESULT_W){1'b0}}, out_res_reg};

    always_comb begin
        in_vld_next  = (s_tvalid && s_tready) || (in_vld_reg && !advance);
        out_vld_next = advance ? res_hit : (out_vld_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            mask_reg    <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready) begin
                mask_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res_hit) begin
            out_res_reg <= res;
        end
    end

    nsc_sentence_core #(
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (advance),
        .rx_byte     (in_byte_reg),
        .filter_mask (mask_reg),
        .res_hit     (res_hit),
        .res         (res)
    );

    a_result_from_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance))
        else $error("result raised without a byte being processed");

    a_enabled_needs_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.type_enabled |-> out_res_reg.sentence_type != TYPE_UNKNOWN)
        else $error("unknown sentence type reported as enabled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_res_reg.checksum_status != 2'd3)
        else $error("checksum status out of range");

    a_no_lost_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(out_res_reg))
        else $error("stalled result overwritten or dropped");

    a_closing_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_hit |-> in_byte_reg == CHAR_CR || in_byte_reg == CHAR_LF)
        else $error("result produced by a byte other than CR or LF");

endmodule

### design/nsc_sentence_core.sv
// nsc_sentence_core: per-sentence state and the per-byte update logic
// depends on nsc_pkg
module nsc_sentence_core import nsc_pkg::*; #(
    parameter int FIELD_LIMIT = DEFAULT_FIELD_LIMIT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [7:0]        filter_mask,
    output logic              res_hit,
    output nsc_result_t       res
);

    localparam logic [COUNT_W-1:0] CommaCap =
        (FIELD_LIMIT - 1 > 31) ? COUNT_W'(31) : COUNT_W'(FIELD_LIMIT - 1);

    logic               in_sentence_reg, in_sentence_next;
    logic [POS_W-1:0]   char_pos_reg, char_pos_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic               after_star_reg, after_star_next;
    logic [1:0]         hex_seen_reg, hex_seen_next;
    logic [BYTE_W-1:0]  rx_sum_reg, rx_sum_next;
    logic               hex_bad_reg, hex_bad_next;
    logic [COUNT_W-1:0] comma_reg, comma_next;

    sentence_type_t     type_code;
    logic [4:0]         nib;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg <= 1'b0;
            char_pos_reg    <= '0;
            addr_reg        <= '0;
            xor_reg         <= '0;
            after_star_reg  <= 1'b0;
            hex_seen_reg    <= '0;
            rx_sum_reg      <= '0;
            hex_bad_reg     <= 1'b0;
            comma_reg       <= '0;
        end else begin
            in_sentence_reg <= in_sentence_next;
            char_pos_reg    <= char_pos_next;
            addr_reg        <= addr_next;
            xor_reg         <= xor_next;
            after_star_reg  <= after_star_next;
            hex_seen_reg    <= hex_seen_next;
            rx_sum_reg      <= rx_sum_next;
            hex_bad_reg     <= hex_bad_next;
            comma_reg       <= comma_next;
        end
    end

    always_comb begin
        type_code = (char_pos_reg == POS_W'(ADDR_LEN)) ? type_of(addr_reg) : TYPE_UNKNOWN;
        nib       = nibble_of(rx_byte);

        res.sentence_type = type_code;
        res.type_enabled  = (type_code != TYPE_UNKNOWN) &&
                            filter_mask[3'(type_code - TYPE_W'(1))];
        if (!after_star_reg) begin
            res.checksum_status = CK_NO_STAR;
        end else if (hex_seen_reg != 2'd2 || hex_bad_reg || rx_sum_reg != xor_reg) begin
            res.checksum_status = CK_MISMATCH;
        end else begin
            res.checksum_status = CK_OK;
        end
        res.comma_count = comma_reg;

        res_hit          = 1'b0;
        in_sentence_next = in_sentence_reg;
        char_pos_next    = char_pos_reg;
        addr_next        = addr_reg;
        xor_next         = xor_reg;
        after_star_next  = after_star_reg;
        hex_seen_next    = hex_seen_reg;
        rx_sum_next      = rx_sum_reg;
        hex_bad_next     = hex_bad_reg;
        comma_next       = comma_reg;

        if (byte_valid) begin
            if (rx_byte == CHAR_DOLLAR || (in_sentence_reg &&
                    (rx_byte == CHAR_CR || rx_byte == CHAR_LF))) begin
                res_hit          = (rx_byte != CHAR_DOLLAR);
                in_sentence_next = (rx_byte == CHAR_DOLLAR);
                char_pos_next    = '0;
                addr_next        = '0;
                xor_next         = '0;
                after_star_next  = 1'b0;
                hex_seen_next    = '0;
                rx_sum_next      = '0;
                hex_bad_next     = 1'b0;
                comma_next       = '0;
            end else if (in_sentence_reg && !after_star_reg) begin
                if (rx_byte == CHAR_STAR) begin
                    after_star_next = 1'b1;
                end else begin
                    xor_next = xor_reg ^ rx_byte;
                    if (char_pos_reg != POS_W'(ADDR_LEN)) begin
                        addr_next     = {addr_reg[ADDR_W-BYTE_W-1:0], rx_byte};
                        char_pos_next = char_pos_reg + POS_W'(1);
                    end
                    if (rx_byte == CHAR_COMMA && comma_reg < CommaCap) begin
                        comma_next = comma_reg + COUNT_W'(1);
                    end
                end
            end else if (in_sentence_reg && hex_seen_reg != 2'd2) begin
                if (nib[4]) begin
                    hex_bad_next = 1'b1;
                end else begin
                    rx_sum_next = {rx_sum_reg[3:0], nib[3:0]};
                end
                hex_seen_next = hex_seen_reg + 2'd1;
            end
        end
    end

endmodule
